/* sv/pet_pkg.sv */
// Package for the pulse echo timer: shared types, register indexes,
// reset values and mode codes. No dependencies.
package pet_pkg;

   localparam int unsigned COUNT_BITS_DEF = 32;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned PULSE_W     = 24;
   localparam int unsigned LEAD_W      = 16;
   localparam int unsigned TIMEOUT_W   = 32;
   localparam int unsigned DUR_W       = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE           = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_TICKS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAD_TICKS     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_POLARITY = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_POLARITY  = 3'd5;

   localparam logic [1:0] MODE_DRAIN = 2'd0;
   localparam logic [1:0] MODE_WIDTH = 2'd1;

   localparam logic [1:0]           MODE_RST      = MODE_DRAIN;
   localparam logic [PULSE_W-1:0]   PULSE_RST     = 24'd10;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 32'd1000000;
   localparam logic [LEAD_W-1:0]    LEAD_RST      = 16'd100;
   localparam logic                 PULSE_POL_RST = 1'b1;
   localparam logic                 ECHO_POL_RST  = 1'b1;

   typedef struct packed {
      logic [1:0]           mode;
      logic [PULSE_W-1:0]   pulse_ticks;
      logic [TIMEOUT_W-1:0] timeout_ticks;
      logic [LEAD_W-1:0]    lead_ticks;
      logic                 pulse_polarity;
      logic                 echo_polarity;
   } csr_regs_type;

   typedef struct packed {
      logic start_req;
      logic echo_in;
   } req_item_type;

   // Held input item as seen by the core.
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_item_type;

endpackage

/* sv/pet_req_if.sv */
// Request channel of the pulse echo timer: one tick with start request and
// echo sample. Standalone, no package dependency.
interface pet_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic echo_in;

   modport source (output valid, output start_req, output echo_in, input ready);
   modport sink   (input valid, input start_req, input echo_in, output ready);
endinterface

/* sv/pet_rsp_if.sv */
// Result channel of the pulse echo timer: pin drive and measurement result
// for one tick. Standalone, no package dependency.
interface pet_rsp_if;
   logic        valid;
   logic        ready;
   logic        pulse_out;
   logic        pulse_drive;
   logic        busy_res;
   logic        done_res;
   logic        timed_out;
   logic [31:0] duration;

   modport source (output valid, output pulse_out, output pulse_drive, output busy_res,
                   output done_res, output timed_out, output duration, input ready);
   modport sink   (input valid, input pulse_out, input pulse_drive, input busy_res,
                   input done_res, input timed_out, input duration, output ready);
endinterface

/* sv/pet_csr.sv */
// Configuration registers of the pulse echo timer, written through a plain
// write port. Depends on pet_pkg.
module pet_csr
   import pet_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output csr_regs_type           regs
);

   csr_regs_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.mode           <= MODE_RST;
         regs_ff.pulse_ticks    <= PULSE_RST;
         regs_ff.timeout_ticks  <= TIMEOUT_RST;
         regs_ff.lead_ticks     <= LEAD_RST;
         regs_ff.pulse_polarity <= PULSE_POL_RST;
         regs_ff.echo_polarity  <= ECHO_POL_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:           regs_ff.mode           <= csr_wdata[1:0];
            CSR_PULSE_TICKS:    regs_ff.pulse_ticks    <= csr_wdata[PULSE_W-1:0];
            CSR_TIMEOUT_TICKS:  regs_ff.timeout_ticks  <= csr_wdata[TIMEOUT_W-1:0];
            CSR_LEAD_TICKS:     regs_ff.lead_ticks     <= csr_wdata[LEAD_W-1:0];
            CSR_PULSE_POLARITY: regs_ff.pulse_polarity <= csr_wdata[0];
            CSR_ECHO_POLARITY:  regs_ff.echo_polarity  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign regs = regs_ff;

endmodule

/* sv/pet_in_stage.sv */
// Input register of the pulse echo timer: holds one request tick until the
// core takes it. Depends on pet_pkg and pet_req_if.
module pet_in_stage
   import pet_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   pet_req_if.sink        req,
   input  logic           take,
   output stage_item_type stage
);

   logic         valid_ff;
   req_item_type item_ff;

   // Refill in the same cycle the core drains the register.
   assign req.ready = !valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.start_req <= req.start_req;
         item_ff.echo_in   <= req.echo_in;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

/* sv/pet_core.sv */
// Measurement sequencer of the pulse echo timer: phase state, counters and
// the result register, one tick per transfer. Depends on pet_pkg, pet_rsp_if.
module pet_core
   import pet_pkg::*;
#(
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  csr_regs_type   regs,
   input  stage_item_type stage,
   output logic           take,
   pet_rsp_if.source      rsp
);

   localparam int unsigned CMP_W = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;

   typedef enum logic [2:0] {
      PH_IDLE, PH_DPULSE, PH_DMEAS, PH_LEAD, PH_EPULSE, PH_WAIT, PH_EMEAS
   } phase_type;

   typedef logic [COUNT_BITS-1:0] count_type;

   phase_type          phase_ff,   phase_in;
   logic [PULSE_W-1:0] pcnt_ff,    pcnt_in;
   count_type          since_ff,   since_in;
   count_type          meas_ff,    meas_in;
   logic               lvl_ff,     lvl_in;
   logic               drv_ff,     drv_in;

   logic               rsp_valid_ff;
   logic               out_lvl_ff, out_drv_ff, busy_ff, done_ff, tmo_ff;
   logic [DUR_W-1:0]   dur_ff;

   logic               out_lvl, out_drv, done, tmo;
   count_type          dur;
   logic [DUR_W-1:0]   dur_sat;

   function automatic count_type sat_inc(input count_type v);
      return (v == '1) ? v : v + count_type'(1);
   endfunction

   function automatic logic expired(input count_type v, input logic [TIMEOUT_W-1:0] lim);
      return (CMP_W'(v) > CMP_W'(lim)) || (v == '1);
   endfunction

   assign take = stage.valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      logic active;
      active   = (stage.item.echo_in == regs.echo_polarity);
      phase_in = phase_ff;
      pcnt_in  = pcnt_ff;
      since_in = since_ff;
      meas_in  = meas_ff;
      lvl_in   = lvl_ff;
      drv_in   = drv_ff;
      done     = 1'b0;
      tmo      = 1'b0;
      dur      = '0;

      // Start handling: the start tick is already the first tick of the first phase.
      if (phase_ff != PH_IDLE) begin
         since_in = sat_inc(since_ff);
      end else if (stage.item.start_req) begin
         since_in = '0;
         drv_in   = 1'b1;
         if (regs.mode == MODE_DRAIN) begin
            lvl_in = regs.pulse_polarity;
            if (regs.pulse_ticks != '0) begin
               phase_in = PH_DPULSE;
               pcnt_in  = regs.pulse_ticks;
            end else begin
               phase_in = PH_DMEAS;
               meas_in  = '0;
            end
         end else begin
            lvl_in = !regs.pulse_polarity;
            if (regs.lead_ticks != '0) begin
               phase_in = PH_LEAD;
               pcnt_in  = PULSE_W'(regs.lead_ticks);
            end else begin
               lvl_in = regs.pulse_polarity;
               if (regs.pulse_ticks != '0) begin
                  phase_in = PH_EPULSE;
                  pcnt_in  = regs.pulse_ticks;
               end else begin
                  lvl_in   = !regs.pulse_polarity;
                  phase_in = PH_WAIT;
                  meas_in  = '0;
               end
            end
         end
      end
      out_lvl = lvl_in;
      out_drv = drv_in;

      case (phase_in)
         PH_DPULSE: begin
            pcnt_in = pcnt_in - PULSE_W'(1);
            if (pcnt_in == '0) begin
               phase_in = PH_DMEAS;
               meas_in  = '0;
            end
         end
         PH_DMEAS: begin
            if (!active) begin
               done = 1'b1;
               dur  = meas_in;
            end else if (expired(meas_in, regs.timeout_ticks)) begin
               done = 1'b1;
               tmo  = 1'b1;
            end else begin
               meas_in = sat_inc(meas_in);
            end
         end
         PH_LEAD: begin
            pcnt_in = pcnt_in - PULSE_W'(1);
            if (pcnt_in == '0) begin
               lvl_in = regs.pulse_polarity;
               if (regs.pulse_ticks != '0) begin
                  phase_in = PH_EPULSE;
                  pcnt_in  = regs.pulse_ticks;
               end else begin
                  lvl_in   = !regs.pulse_polarity;
                  phase_in = PH_WAIT;
                  meas_in  = '0;
               end
            end
         end
         PH_EPULSE: begin
            pcnt_in = pcnt_in - PULSE_W'(1);
            if (pcnt_in == '0) begin
               lvl_in   = !regs.pulse_polarity;
               phase_in = PH_WAIT;
               meas_in  = '0;
            end
         end
         PH_WAIT: begin
            if (active) begin
               if (regs.mode == MODE_WIDTH) begin
                  phase_in = PH_EMEAS;
                  meas_in  = count_type'(1);
               end else begin
                  done = 1'b1;
                  dur  = meas_in;
               end
            end else if (expired(since_in, regs.timeout_ticks)) begin
               done = 1'b1;
               tmo  = 1'b1;
            end else begin
               meas_in = sat_inc(meas_in);
            end
         end
         PH_EMEAS: begin
            if (!active) begin
               done = 1'b1;
               dur  = meas_in;
            end else if (expired(since_in, regs.timeout_ticks)) begin
               done = 1'b1;
               tmo  = 1'b1;
            end else begin
               meas_in = sat_inc(meas_in);
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (done) begin
         phase_in = PH_IDLE;
      end
   end

   // Clamp to the 32-bit result field when the counters are wider.
   assign dur_sat = (CMP_W'(dur) > CMP_W'({DUR_W{1'b1}})) ? {DUR_W{1'b1}}
                                                          : DUR_W'(CMP_W'(dur));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pcnt_ff      <= '0;
         since_ff     <= '0;
         meas_ff      <= '0;
         lvl_ff       <= 1'b0;
         drv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         pcnt_ff      <= pcnt_in;
         since_ff     <= since_in;
         meas_ff      <= meas_in;
         lvl_ff       <= lvl_in;
         drv_ff       <= drv_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_lvl_ff <= out_lvl;
         out_drv_ff <= out_drv;
         busy_ff    <= (phase_in != PH_IDLE);
         done_ff    <= done;
         tmo_ff     <= tmo;
         dur_ff     <= dur_sat;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pulse_out   = out_lvl_ff;
   assign rsp.pulse_drive = out_drv_ff;
   assign rsp.busy_res    = busy_ff;
   assign rsp.done_res    = done_ff;
   assign rsp.timed_out   = tmo_ff;
   assign rsp.duration    = dur_ff;

endmodule

/* sv/pulse_echo_timer_unit.sv */
// Top level of the pulse echo timer: configuration registers, input register
// and measurement core. Depends on pet_pkg, pet_req_if, pet_rsp_if and the pet_ modules.
//
// Usage:
//   Each transfer on req_chan is one timer tick: a start request and the
//   sampled echo level. Each tick gives exactly one transfer on rsp_chan with
//   the pin level and drive for that tick, busy, done, the timeout flag and
//   the duration in ticks (zero unless done, zero on timeout).
//   The csr_ port writes one register per cycle with csr_we high; registers
//   are read live, so write them only while no measurement runs.
//   A req_chan transfer reaches rsp_chan through the input register, then
//   the result register behind the sequencer logic.
//   Throughput is one tick per cycle while rsp_chan takes its results; the
//   sequencer updates its phase and counters combinationally for each tick.
//   A stall on rsp_chan holds the result; the input register still takes one
//   more tick if it is empty, then req_chan ready drops until the result is taken.
//   Synchronous reset returns the sequencer to idle with counters cleared and
//   the pin undriven, and loads the register reset values.
module pulse_echo_timer_unit
   import pet_pkg::*;
#(
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   pet_req_if.sink                req_chan,
   pet_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_regs_type   regs;
   stage_item_type stage;
   logic           take;

   pet_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   pet_in_stage u_in_stage (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .take  (take),
      .stage (stage)
   );

   pet_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .regs  (regs),
      .stage (stage),
      .take  (take),
      .rsp   (rsp_chan)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for pulse_echo_timer_unit: directed and random echo ticks, checked
// tick by tick against a behavioral model of the pulse/echo sequencer.
// Depends on pet_pkg, pet_req_if, pet_rsp_if and the RTL of the unit.
module tb_top;
   import pet_pkg::*;

   localparam logic [1:0] MODE_UNTIL     = 2'd2;
   localparam logic [1:0] MODE_UNTIL_ALT = 2'd3;
   localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF;
   localparam longint unsigned DUR_MAX   = 64'hFFFF_FFFF;
   localparam int CYCLE_LIMIT   = 3000000;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_GAP       = 14;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_DRAIN_PULSE, SEQ_DRAIN_MEAS, SEQ_LEAD,
      SEQ_ECHO_PULSE, SEQ_WAIT, SEQ_ECHO_MEAS
   } seq_phase_type;

   typedef struct packed {
      logic start_req;
      logic echo_in;
      logic lazy;
   } tick_item_type;

   typedef struct packed {
      logic             pulse_out;
      logic             pulse_drive;
      logic             busy_res;
      logic             done_res;
      logic             timed_out;
      logic [DUR_W-1:0] duration;
   } tick_result_type;

   typedef struct packed {
      logic            lazy;
      tick_result_type res;
   } predicted_tick_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pet_req_if req_chan();
   pet_rsp_if rsp_chan();

   pulse_echo_timer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model state and its copy of the registers
   csr_regs_type       cfg;
   seq_phase_type      seq_phase;
   logic [PULSE_W-1:0] phase_left;
   longint unsigned    since_start;
   longint unsigned    measure_count;
   logic               pin_level;
   logic               pin_driven;

   tick_item_type      tick_q[$];
   tick_item_type      tick_cur = '0;
   logic               tick_loaded;
   int                 tick_gap;
   int                 rsp_stall;
   int                 ticks_sent  = 0;
   int                 ticks_taken = 0;
   int                 errors      = 0;
   int unsigned        cycle_count = 0;
   logic               req_fire;
   logic               rsp_fire;
   predicted_tick_type predicted_ticks[$];

   function automatic longint unsigned sat_bump(longint unsigned v);
      return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
   endfunction

   function automatic logic past_timeout(longint unsigned elapsed);
      return (elapsed > cfg.timeout_ticks) || (elapsed >= COUNT_MAX);
   endfunction

   function automatic void enter_echo_wait();
      pin_level     = ~cfg.pulse_polarity;
      seq_phase     = SEQ_WAIT;
      measure_count = 0;
   endfunction

   function automatic void enter_echo_pulse();
      pin_level = cfg.pulse_polarity;
      if (cfg.pulse_ticks != 0) begin
         seq_phase  = SEQ_ECHO_PULSE;
         phase_left = cfg.pulse_ticks;
      end else begin
         enter_echo_wait();
      end
   endfunction

   // One timer tick: start handling, then the phase step on this echo sample.
   function automatic tick_result_type advance_timer(logic start, logic echo);
      tick_result_type r;
      logic            active;
      longint unsigned dur;
      r      = '0;
      dur    = 0;
      active = (echo == cfg.echo_polarity);
      if (seq_phase != SEQ_IDLE) begin
         since_start = sat_bump(since_start);
      end else if (start) begin
         since_start = 0;
         pin_driven  = 1'b1;
         if (cfg.mode == MODE_DRAIN) begin
            pin_level = cfg.pulse_polarity;
            if (cfg.pulse_ticks != 0) begin
               seq_phase  = SEQ_DRAIN_PULSE;
               phase_left = cfg.pulse_ticks;
            end else begin
               seq_phase     = SEQ_DRAIN_MEAS;
               measure_count = 0;
            end
         end else begin
            pin_level = ~cfg.pulse_polarity;
            if (cfg.lead_ticks != 0) begin
               seq_phase  = SEQ_LEAD;
               phase_left = PULSE_W'(cfg.lead_ticks);
            end else begin
               enter_echo_pulse();
            end
         end
      end
      r.pulse_out   = pin_level;
      r.pulse_drive = pin_driven;

      case (seq_phase)
         SEQ_DRAIN_PULSE: begin
            phase_left = phase_left - 1'b1;
            if (phase_left == 0) begin
               seq_phase     = SEQ_DRAIN_MEAS;
               measure_count = 0;
            end
         end
         SEQ_DRAIN_MEAS: begin
            if (!active) begin
               r.done_res = 1'b1;
               dur        = measure_count;
            end else if (past_timeout(measure_count)) begin
               r.done_res  = 1'b1;
               r.timed_out = 1'b1;
            end else begin
               measure_count = sat_bump(measure_count);
            end
         end
         SEQ_LEAD: begin
            phase_left = phase_left - 1'b1;
            if (phase_left == 0) enter_echo_pulse();
         end
         SEQ_ECHO_PULSE: begin
            phase_left = phase_left - 1'b1;
            if (phase_left == 0) enter_echo_wait();
         end
         SEQ_WAIT: begin
            if (active) begin
               if (cfg.mode == MODE_WIDTH) begin
                  seq_phase     = SEQ_ECHO_MEAS;
                  measure_count = 1;
               end else begin
                  r.done_res = 1'b1;
                  dur        = measure_count;
               end
            end else if (past_timeout(since_start)) begin
               r.done_res  = 1'b1;
               r.timed_out = 1'b1;
            end else begin
               measure_count = sat_bump(measure_count);
            end
         end
         SEQ_ECHO_MEAS: begin
            if (!active) begin
               r.done_res = 1'b1;
               dur        = measure_count;
            end else if (past_timeout(since_start)) begin
               r.done_res  = 1'b1;
               r.timed_out = 1'b1;
            end else begin
               measure_count = sat_bump(measure_count);
            end
         end
         default: seq_phase = SEQ_IDLE;
      endcase
      if (r.done_res) seq_phase = SEQ_IDLE;
      r.busy_res = (seq_phase != SEQ_IDLE);
      r.duration = (dur > DUR_MAX) ? '1 : dur[DUR_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [DUR_W-1:0] want,
                                       logic [DUR_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   task automatic push_tick(logic start, logic echo, logic lazy);
      tick_item_type it;
      it.start_req = start;
      it.echo_in   = echo;
      it.lazy      = lazy;
      tick_q.push_back(it);
      ticks_sent++;
   endtask

   task automatic wait_taken();
      while (tick_q.size() != 0 || ticks_taken != ticks_sent) @(negedge clock);
   endtask

   // Runs any open measurement to its end, then lets the pipeline drain.
   task automatic settle();
      wait_taken();
      while (seq_phase != SEQ_IDLE) begin
         case (seq_phase)
            SEQ_DRAIN_PULSE, SEQ_LEAD, SEQ_ECHO_PULSE:
               repeat (phase_left) push_tick(1'b0, 1'($urandom_range(1, 0)), 1'b0);
            SEQ_WAIT: push_tick(1'b0, cfg.echo_polarity, 1'b0);
            default:  push_tick(1'b0, ~cfg.echo_polarity, 1'b0);
         endcase
         wait_taken();
      end
      while (predicted_ticks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MODE:           cfg.mode           = data[1:0];
         CSR_PULSE_TICKS:    cfg.pulse_ticks    = data[PULSE_W-1:0];
         CSR_TIMEOUT_TICKS:  cfg.timeout_ticks  = data[TIMEOUT_W-1:0];
         CSR_LEAD_TICKS:     cfg.lead_ticks     = data[LEAD_W-1:0];
         CSR_PULSE_POLARITY: cfg.pulse_polarity = data[0];
         CSR_ECHO_POLARITY:  cfg.echo_polarity  = data[0];
         default: ;
      endcase
   endtask

   // request driver: one tick on the bus until its transfer, random gaps after lazy ticks
   always @(negedge clock) begin
      if (reset) begin
         tick_loaded = 1'b0;
         tick_gap    = 0;
         req_chan.valid <= 1'b0;
      end else begin
         if (tick_loaded && req_fire) tick_loaded = 1'b0;
         if (!tick_loaded) begin
            if (tick_gap > 0) begin
               tick_gap--;
            end else if (tick_q.size() != 0) begin
               tick_cur    = tick_q.pop_front();
               tick_loaded = 1'b1;
               tick_gap    = tick_cur.lazy ? $urandom_range(MAX_GAP, 0) : 0;
            end
         end
         req_chan.valid     <= tick_loaded;
         req_chan.start_req <= tick_cur.start_req;
         req_chan.echo_in   <= tick_cur.echo_in;
      end
   end

   // result ready: random stall drawn after a result transfer when the next result is lazy
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_fire && predicted_ticks.size() != 0 && predicted_ticks[0].lazy)
            rsp_stall = $urandom_range(MAX_GAP, 0);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // monitor: predict on each request transfer, compare on each result transfer
   always @(posedge clock) begin
      predicted_tick_type want;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_chan.valid && req_chan.ready;
         rsp_fire <= rsp_chan.valid && rsp_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            want.lazy = tick_cur.lazy;
            want.res  = advance_timer(req_chan.start_req, req_chan.echo_in);
            predicted_ticks.push_back(want);
            ticks_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (predicted_ticks.size() == 0) begin
               errors++;
               $display("%0t: result with nothing predicted, expected none, got duration %0h",
                        $time, rsp_chan.duration);
            end else begin
               want = predicted_ticks.pop_front();
               check_field("pulse_out", want.res.pulse_out, rsp_chan.pulse_out);
               check_field("pulse_drive", want.res.pulse_drive, rsp_chan.pulse_drive);
               check_field("busy_res", want.res.busy_res, rsp_chan.busy_res);
               check_field("done_res", want.res.done_res, rsp_chan.done_res);
               check_field("timed_out", want.res.timed_out, rsp_chan.timed_out);
               check_field("duration", want.res.duration, rsp_chan.duration);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pulse_echo_timer_unit verification failed");
         $finish;
      end
   end

   initial begin
      int   target;
      int   span;
      logic act;
      logic lazy;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_MODE;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.start_req = 1'b0;
      req_chan.echo_in   = 1'b0;
      rsp_chan.ready     = 1'b0;

      cfg.mode           = MODE_RST;
      cfg.pulse_ticks    = PULSE_RST;
      cfg.timeout_ticks  = TIMEOUT_RST;
      cfg.lead_ticks     = LEAD_RST;
      cfg.pulse_polarity = PULSE_POL_RST;
      cfg.echo_polarity  = ECHO_POL_RST;
      seq_phase          = SEQ_IDLE;
      phase_left         = '0;
      since_start        = 0;
      measure_count      = 0;
      pin_level          = 1'b0;
      pin_driven         = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: undriven pin while idle, then a drain run with the default pulse
      push_tick(0, 0, 1);
      push_tick(0, 1, 1);
      push_tick(1, 1, 1);
      settle();

      // drain with no pulse: measures from the start tick, hits the timeout,
      // ignores a start while busy, then ends at once on an inactive echo
      csr_write(CSR_MODE, MODE_DRAIN);
      csr_write(CSR_PULSE_TICKS, 0);
      csr_write(CSR_TIMEOUT_TICKS, 1);
      push_tick(1, 1, 1);
      push_tick(1, 1, 0);
      push_tick(0, 1, 0);
      push_tick(0, 1, 1);
      push_tick(1, 0, 1);
      settle();

      // inverted polarities, largest timeout
      csr_write(CSR_PULSE_TICKS, 2);
      csr_write(CSR_PULSE_POLARITY, 0);
      csr_write(CSR_ECHO_POLARITY, 0);
      csr_write(CSR_TIMEOUT_TICKS, 32'hFFFF_FFFF);
      push_tick(1, 1, 0);
      push_tick(0, 1, 0);
      push_tick(0, 0, 0);
      push_tick(0, 0, 0);
      push_tick(0, 1, 0);
      settle();

      // echo width with zero lead and pulse: the wait step runs on the start tick
      csr_write(CSR_MODE, MODE_WIDTH);
      csr_write(CSR_LEAD_TICKS, 0);
      csr_write(CSR_PULSE_TICKS, 0);
      csr_write(CSR_PULSE_POLARITY, 1);
      csr_write(CSR_ECHO_POLARITY, 1);
      csr_write(CSR_TIMEOUT_TICKS, 5);
      push_tick(1, 1, 1);
      push_tick(0, 1, 1);
      push_tick(0, 0, 1);
      settle();

      // time until echo: no echo arrives, so the wait times out
      csr_write(CSR_MODE, MODE_UNTIL);
      csr_write(CSR_LEAD_TICKS, 1);
      csr_write(CSR_PULSE_TICKS, 1);
      csr_write(CSR_TIMEOUT_TICKS, 3);
      push_tick(1, 0, 1);
      repeat (5) push_tick(0, 0, 1);
      settle();

      // mode three behaves as time until echo
      csr_write(CSR_MODE, MODE_UNTIL_ALT);
      csr_write(CSR_LEAD_TICKS, 0);
      push_tick(1, 0, 1);
      push_tick(0, 0, 1);
      push_tick(0, 1, 1);
      settle();

      // random settings, mostly complete measurements with random timing
      for (int round = 0; round < 8; round++) begin
         csr_write(CSR_MODE, $urandom_range(3, 0));
         csr_write(CSR_PULSE_TICKS, $urandom_range(6, 0));
         csr_write(CSR_LEAD_TICKS, $urandom_range(6, 0));
         case ($urandom_range(3, 0))
            0:       csr_write(CSR_TIMEOUT_TICKS, 0);
            1:       csr_write(CSR_TIMEOUT_TICKS, $urandom_range(12, 1));
            2:       csr_write(CSR_TIMEOUT_TICKS, $urandom_range(40, 13));
            default: csr_write(CSR_TIMEOUT_TICKS, 32'hFFFF_FFFF);
         endcase
         csr_write(CSR_PULSE_POLARITY, $urandom_range(1, 0));
         csr_write(CSR_ECHO_POLARITY, $urandom_range(1, 0));
         target = ticks_sent + 35;
         while (ticks_sent < target) begin
            lazy = ($urandom_range(3, 0) != 0);
            act  = cfg.echo_polarity;
            if ($urandom_range(9, 0) < 8) begin
               push_tick(1, 1'($urandom_range(1, 0)), lazy);
               span = (cfg.mode == MODE_DRAIN) ? int'(cfg.pulse_ticks)
                                               : int'(cfg.lead_ticks) + int'(cfg.pulse_ticks);
               // stray starts during the lead and pulse must be ignored
               repeat (span)
                  push_tick($urandom_range(7, 0) == 0, 1'($urandom_range(1, 0)), lazy);
               if (cfg.mode != MODE_DRAIN)
                  repeat ($urandom_range(8, 0)) push_tick(0, ~act, lazy);
               repeat ($urandom_range(8, 0)) push_tick(0, act, lazy);
               push_tick(0, ~act, lazy);
            end else begin
               repeat ($urandom_range(4, 1))
                  push_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), lazy);
            end
         end
         settle();
      end

      // largest pulse and lead: idle ticks only, pin holds its last level and drive
      csr_write(CSR_PULSE_TICKS, 24'hFF_FFFF);
      csr_write(CSR_LEAD_TICKS, 16'hFFFF);
      csr_write(CSR_TIMEOUT_TICKS, 32'hFFFF_FFFF);
      csr_write(CSR_MODE, MODE_UNTIL_ALT);
      repeat (12) push_tick(0, 1'($urandom_range(1, 0)), 1);
      settle();

      // long lead in echo width mode, sent back to back
      csr_write(CSR_MODE, MODE_WIDTH);
      csr_write(CSR_PULSE_TICKS, 3);
      csr_write(CSR_LEAD_TICKS, 40);
      push_tick(1, 0, 0);
      settle();

      if (errors == 0)
         $display("pulse_echo_timer_unit verification clean");
      else
         $display("pulse_echo_timer_unit verification failed");
      $finish;
   end

endmodule

/* pulse_echo_timer_unit.f */
sv/pet_pkg.sv
sv/pet_req_if.sv
sv/pet_rsp_if.sv
sv/pet_csr.sv
sv/pet_in_stage.sv
sv/pet_core.sv
sv/pulse_echo_timer_unit.sv
tb/tb_top.sv
